// ----- design/serial_frame_deframer_sum8_assert.svh -----
// assertion macros for the frame deframer checker
// needs a clock and an active-high reset passed by the caller
`ifndef SERIAL_FRAME_DEFRAMER_SUM8_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_SUM8_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SFD_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, quiet during reset
`define SFD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, also checked across reset
`define SFD_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- design/sfd_pkg.sv -----
// shared types and constants of the frame deframer
// no dependencies
package sfd_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int STORE_DEPTH     = MAX_FRAME_BYTES - 4;
  localparam int MIN_FRAME_LEN   = 5;
  localparam int IDX_W           = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W          = IDX_W + 1;
  localparam int MEM_DEPTH       = 2 ** ADDR_W;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the config port
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd2;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [6:0] MAX_LEN_RST       = 7'd60;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CSUM_ERR = 2'd1,
    KIND_LEN_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SHOW
  } back_state_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [6:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic              bank;
    logic [IDX_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic done;
    logic bank;
  } release_t;

endpackage

// ----- design/sfd_if.sv -----
// byte and result channel interfaces of the frame deframer
// no dependencies
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface sfd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_kind, output out_byte, output out_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_last,
                output ready);
endinterface

// ----- design/sfd_front.sv -----
// front part: frame hunt, length check, checksum, payload writes
// depends on sfd_pkg
module sfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  sfd_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  push,
  output sfd_pkg::cmd_t         push_cmd,
  output sfd_pkg::wr_t          wr,
  input  sfd_pkg::release_t     rel
);

  sfd_pkg::phase_t           phase, phase_next;
  logic [7:0]                expected_len, expected_len_next;
  logic [7:0]                running_sum, running_sum_next;
  logic [sfd_pkg::IDX_W-1:0] pidx, pidx_next;
  logic                      wbank, wbank_next;
  logic [1:0]                bank_busy, bank_busy_next;
  logic [7:0]                limit;
  logic                      acc;

  assign in_ready = !q_full && !bank_busy[wbank];
  assign acc      = in_valid && in_ready;
  assign limit    = (cfg.max_len > 7'(sfd_pkg::MAX_FRAME_BYTES)) ?
                    8'(sfd_pkg::MAX_FRAME_BYTES) : {1'b0, cfg.max_len};

  always_comb begin
    phase_next        = phase;
    expected_len_next = expected_len;
    running_sum_next  = running_sum;
    pidx_next         = pidx;
    wbank_next        = wbank;
    bank_busy_next    = bank_busy;
    push              = 1'b0;
    push_cmd          = '0;
    wr.en             = 1'b0;
    wr.addr           = {wbank, pidx};
    wr.data           = in_byte;
    if (rel.done) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (acc) begin
      unique case (phase)
        sfd_pkg::PH_HEAD1: begin
          if (in_byte == cfg.header_first) begin
            running_sum_next = in_byte;
            phase_next       = sfd_pkg::PH_HEAD2;
          end
        end
        sfd_pkg::PH_HEAD2: begin
          // a mismatch here is not retried as a first header
          if (in_byte == cfg.header_second) begin
            running_sum_next = running_sum + in_byte;
            phase_next       = sfd_pkg::PH_LEN;
          end else begin
            phase_next = sfd_pkg::PH_HEAD1;
          end
        end
        sfd_pkg::PH_LEN: begin
          expected_len_next = in_byte;
          if (in_byte < 8'(sfd_pkg::MIN_FRAME_LEN) || in_byte > limit) begin
            push          = 1'b1;
            push_cmd.kind = sfd_pkg::KIND_LEN_ERR;
            phase_next    = sfd_pkg::PH_HEAD1;
          end else begin
            running_sum_next = running_sum + in_byte;
            pidx_next        = '0;
            phase_next       = sfd_pkg::PH_DATA;
          end
        end
        sfd_pkg::PH_DATA: begin
          wr.en            = 1'b1;
          running_sum_next = running_sum + in_byte;
          pidx_next        = pidx + sfd_pkg::IDX_W'(1);
          // bytes so far plus checksum reach the frame length
          if (8'(pidx) + 8'(sfd_pkg::MIN_FRAME_LEN) >= expected_len) begin
            phase_next = sfd_pkg::PH_CSUM;
          end
        end
        sfd_pkg::PH_CSUM: begin
          push = 1'b1;
          if (running_sum == in_byte) begin
            push_cmd.kind            = sfd_pkg::KIND_DATA;
            push_cmd.bank            = wbank;
            push_cmd.count           = pidx;
            bank_busy_next[wbank]    = 1'b1;
            wbank_next               = !wbank;
          end else begin
            push_cmd.kind = sfd_pkg::KIND_CSUM_ERR;
          end
          phase_next = sfd_pkg::PH_HEAD1;
        end
        default: begin
          phase_next = sfd_pkg::PH_HEAD1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= sfd_pkg::PH_HEAD1;
      expected_len <= '0;
      running_sum  <= '0;
      pidx         <= '0;
      wbank        <= 1'b0;
      bank_busy    <= '0;
    end else begin
      phase        <= phase_next;
      expected_len <= expected_len_next;
      running_sum  <= running_sum_next;
      pidx         <= pidx_next;
      wbank        <= wbank_next;
      bank_busy    <= bank_busy_next;
    end
  end

endmodule

// ----- design/sfd_cmd_queue.sv -----
// short command queue between front and back parts
// depends on sfd_pkg
module sfd_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sfd_pkg::cmd_t pop_cmd,
  output logic          empty
);

  sfd_pkg::cmd_t              entries [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [sfd_pkg::QCNT_W-1:0] count;
  logic                       do_push, do_pop;

  assign full    = (count == sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sfd_pkg::QPTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + sfd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sfd_pkg::QPTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + sfd_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + sfd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - sfd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// ----- design/sfd_back.sv -----
// back part: payload store and result drain with output register
// depends on sfd_pkg
module sfd_back (
  input  logic              clk,
  input  logic              rst,
  input  sfd_pkg::wr_t      wr,
  input  logic              q_empty,
  input  sfd_pkg::cmd_t     q_cmd,
  output logic              pop,
  output sfd_pkg::release_t rel,
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::kind_t    out_kind,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic [7:0]                 mem [sfd_pkg::MEM_DEPTH];
  logic [7:0]                 rd_data;
  logic                       rd_en;
  logic [sfd_pkg::ADDR_W-1:0] rd_addr;

  sfd_pkg::back_state_t       state, state_next;
  logic                       cur_bank, cur_bank_next;
  logic [sfd_pkg::IDX_W-1:0]  cur_count, cur_count_next;
  logic [sfd_pkg::IDX_W-1:0]  idx, idx_next, idx_inc;
  logic                       out_valid_next;
  sfd_pkg::kind_t             out_kind_next;
  logic [7:0]                 out_byte_next;
  logic                       out_last_next;

  assign idx_inc = idx + sfd_pkg::IDX_W'(1);

  always_comb begin
    state_next     = state;
    cur_bank_next  = cur_bank;
    cur_count_next = cur_count;
    idx_next       = idx;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = {cur_bank, idx};
    rel            = '0;
    unique case (state)
      sfd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (q_cmd.kind == sfd_pkg::KIND_DATA) begin
            cur_bank_next  = q_cmd.bank;
            cur_count_next = q_cmd.count;
            idx_next       = '0;
            rd_en          = 1'b1;
            rd_addr        = {q_cmd.bank, {sfd_pkg::IDX_W{1'b0}}};
            state_next     = sfd_pkg::BK_FETCH;
          end else begin
            out_valid_next = 1'b1;
            out_kind_next  = q_cmd.kind;
            out_byte_next  = '0;
            out_last_next  = 1'b1;
            state_next     = sfd_pkg::BK_SHOW;
          end
        end
      end
      sfd_pkg::BK_FETCH: begin
        out_valid_next = 1'b1;
        out_kind_next  = sfd_pkg::KIND_DATA;
        out_byte_next  = rd_data;
        out_last_next  = (idx_inc == cur_count);
        state_next     = sfd_pkg::BK_SHOW;
      end
      sfd_pkg::BK_SHOW: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            // hand the drained bank back to the front part
            if (out_kind == sfd_pkg::KIND_DATA) begin
              rel.done = 1'b1;
              rel.bank = cur_bank;
            end
            state_next = sfd_pkg::BK_IDLE;
          end else begin
            idx_next   = idx_inc;
            rd_en      = 1'b1;
            rd_addr    = {cur_bank, idx_inc};
            state_next = sfd_pkg::BK_FETCH;
          end
        end
      end
      default: begin
        state_next = sfd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sfd_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_bank  <= cur_bank_next;
    cur_count <= cur_count_next;
    idx       <= idx_next;
    out_kind  <= out_kind_next;
    out_byte  <= out_byte_next;
    out_last  <= out_last_next;
  end

endmodule

// ----- design/serial_frame_deframer_sum8.sv -----
// top level of the serial frame deframer with 8-bit additive checksum
// depends on sfd_pkg, sfd_if, sfd_front, sfd_cmd_queue, sfd_back
//
// Hunts received bytes for frames of the form header_first, header_second, length,
// payload, checksum, where length is the whole frame size (5 up to max_frame_len,
// capped at 64) and the checksum is the low 8 bits of the sum of everything before
// it. A good frame drains as one transfer per payload byte with out_last on the
// final one; a bad checksum or an out-of-range length gives a single error transfer
// with out_byte zero and out_last set. Bytes outside frames give nothing. The
// front part takes one byte per cycle; it holds off only while its two-entry
// command queue is full or while the payload bank it would write next is still
// being drained. Payload sits in a two-bank store (one bank per frame in flight)
// with a registered read port, so the back part fetches each payload byte before
// it shows it and takes up each command from its idle state; no new result is
// offered while a byte is being fetched. A frame drains while the next frame is
// already being received. The store needs no clearing pass after reset: every
// entry read back was written earlier in the same frame. Configuration writes are
// to be made only while the block is idle.
module serial_frame_deframer_sum8 (
  input  logic       clk,
  input  logic       rst,
  sfd_rx_if.sink     rx,
  sfd_res_if.source  res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  sfd_pkg::cfg_t     cfg;
  sfd_pkg::cmd_t     push_cmd, pop_cmd;
  sfd_pkg::wr_t      wr;
  sfd_pkg::release_t rel;
  sfd_pkg::kind_t    out_kind;
  logic              push, pop, q_full, q_empty;

  // config registers, index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= sfd_pkg::HEADER_FIRST_RST;
      cfg.header_second <= sfd_pkg::HEADER_SECOND_RST;
      cfg.max_len       <= sfd_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::REG_HEADER_FIRST:  cfg.header_first  <= cfg_data;
        sfd_pkg::REG_HEADER_SECOND: cfg.header_second <= cfg_data;
        sfd_pkg::REG_MAX_FRAME_LEN: cfg.max_len       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // hunt, classify and store payload
  sfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (rx.valid),
    .in_byte  (rx.in_byte),
    .in_ready (rx.ready),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .wr       (wr),
    .rel      (rel)
  );

  // decouples frame reception from result drain
  sfd_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // payload store and output register
  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .rel       (rel),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_kind  (out_kind),
    .out_byte  (res.out_byte),
    .out_last  (res.out_last)
  );

  assign res.out_kind = out_kind;

endmodule

// ----- design/sfd_checker.sv -----
// port-level checks on the frame deframer, bound to the top level
// depends on sfd_pkg and serial_frame_deframer_sum8_assert.svh
`include "serial_frame_deframer_sum8_assert.svh"

module sfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [7:0] res_byte,
  input logic       res_last
);

  logic        is_err;
  logic [10:0] res_word;

  assign is_err   = (res_kind == sfd_pkg::KIND_CSUM_ERR) ||
                    (res_kind == sfd_pkg::KIND_LEN_ERR);
  assign res_word = {res_kind, res_byte, res_last};

  // an error result stands alone with a zero byte
  `SFD_ASSERT_NOW(a_err_shape, clk, rst, res_valid && is_err, res_last && res_byte == 8'h00)

  // a waiting result holds until taken
  `SFD_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_word))

  // nothing is offered straight after reset
  `SFD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !res_valid)

endmodule

bind serial_frame_deframer_sum8 sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.out_kind),
  .res_byte  (res.out_byte),
  .res_last  (res.out_last)
);

// ----- tb/sv/serial_frame_deframer_sum8_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the serial frame deframer with 8-bit additive checksum
// depends on sfd_pkg, sfd_if and the serial_frame_deframer_sum8 top level
// a local frame hunter predicts every transfer on the result channel
module serial_frame_deframer_sum8_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 110;
  localparam int LONG_HOLD     = 300;

  // ways of spoiling a frame on purpose
  typedef enum int {
    FLAW_NONE,
    FLAW_HEAD2,
    FLAW_CSUM,
    FLAW_TRUNC
  } frame_flaw_t;

  // one transfer on the result channel
  typedef struct packed {
    sfd_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } deframed_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  sfd_rx_if  rx_ch ();
  sfd_res_if res_ch ();

  serial_frame_deframer_sum8 i_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted transfers, oldest first
  deframed_t deframed_q[$];

  // local copy of the registers
  logic [7:0] hdr1;
  logic [7:0] hdr2;
  logic [6:0] max_len;

  // local copy of the frame hunter state
  sfd_pkg::phase_t hunt_ph;
  logic [6:0]      frame_pos;
  logic [7:0]      frame_len;
  logic [7:0]      frame_sum;
  logic [7:0]      payload_mem [sfd_pkg::STORE_DEPTH];

  int fail_count;
  int cycles;
  int frame_bytes;  // bytes sent as part of a frame, noise excluded
  bit idle_on;
  int hold_left;    // long receiver hold-off, counted down by the ready process

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** serial_frame_deframer_sum8: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic int eff_limit();
    return (int'(max_len) > sfd_pkg::MAX_FRAME_BYTES) ? sfd_pkg::MAX_FRAME_BYTES
                                                      : int'(max_len);
  endfunction

  function automatic void push_result(sfd_pkg::kind_t k, logic [7:0] d, logic l);
    deframed_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    deframed_q.push_back(r);
  endfunction

  function automatic void deframe_reset();
    hdr1      = sfd_pkg::HEADER_FIRST_RST;
    hdr2      = sfd_pkg::HEADER_SECOND_RST;
    max_len   = sfd_pkg::MAX_LEN_RST;
    hunt_ph   = sfd_pkg::PH_HEAD1;
    frame_pos = '0;
    frame_len = '0;
    frame_sum = '0;
    deframed_q.delete();
  endfunction

  // one accepted byte through the hunter; queues whatever transfers it causes
  function automatic void deframe_byte(logic [7:0] b);
    int n;
    int lim;
    lim = eff_limit();
    case (hunt_ph)
      sfd_pkg::PH_HEAD1: begin
        frame_pos = '0;
        if (b == hdr1) begin
          frame_sum = b;
          frame_pos = 7'd1;
          hunt_ph   = sfd_pkg::PH_HEAD2;
        end
      end
      sfd_pkg::PH_HEAD2: begin
        // a wrong second header is dropped, not retried as a first header
        if (b == hdr2) begin
          frame_sum = frame_sum + b;
          frame_pos = 7'd2;
          hunt_ph   = sfd_pkg::PH_LEN;
        end else begin
          hunt_ph = sfd_pkg::PH_HEAD1;
        end
      end
      sfd_pkg::PH_LEN: begin
        frame_len = b;
        if (int'(b) < sfd_pkg::MIN_FRAME_LEN || int'(b) > lim) begin
          push_result(sfd_pkg::KIND_LEN_ERR, 8'h00, 1'b1);
          hunt_ph = sfd_pkg::PH_HEAD1;
        end else begin
          frame_sum = frame_sum + b;
          frame_pos = 7'd3;
          hunt_ph   = sfd_pkg::PH_DATA;
        end
      end
      sfd_pkg::PH_DATA: begin
        if (int'(frame_pos) >= 3 && int'(frame_pos) - 3 < sfd_pkg::STORE_DEPTH)
          payload_mem[int'(frame_pos) - 3] = b;
        frame_sum = frame_sum + b;
        frame_pos = frame_pos + 7'd1;
        if (int'(frame_pos) + 1 >= int'(frame_len)) hunt_ph = sfd_pkg::PH_CSUM;
      end
      sfd_pkg::PH_CSUM: begin
        if (frame_sum == b) begin
          n = int'(frame_len) - 4;
          if (int'(frame_len) < sfd_pkg::MIN_FRAME_LEN) n = 0;
          if (n > sfd_pkg::STORE_DEPTH) n = sfd_pkg::STORE_DEPTH;
          for (int i = 0; i < n; i++)
            push_result(sfd_pkg::KIND_DATA, payload_mem[i], i == n - 1);
        end else begin
          push_result(sfd_pkg::KIND_CSUM_ERR, 8'h00, 1'b1);
        end
        hunt_ph = sfd_pkg::PH_HEAD1;
      end
      default: hunt_ph = sfd_pkg::PH_HEAD1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern and checking
  // ---------------------------------------------------------------------------

  // one nonblocking write of ready per edge; long hold wins over short bursts
  initial begin
    int burst;
    burst = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // every result transfer against the oldest prediction
  always @(posedge clk) begin
    deframed_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (deframed_q.size() == 0) begin
        $display("%0t: result expected none got kind %0d byte %02h last %0b", $time,
                 res_ch.out_kind, res_ch.out_byte, res_ch.out_last);
        fail_count++;
      end else begin
        want = deframed_q.pop_front();
        if (res_ch.out_kind !== want.kind) begin
          $display("%0t: out_kind expected %0d got %0d", $time, want.kind, res_ch.out_kind);
          fail_count++;
        end
        if (res_ch.out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, want.data, res_ch.out_byte);
          fail_count++;
        end
        if (res_ch.out_last !== want.last) begin
          $display("%0t: out_last expected %0b got %0b", $time, want.last, res_ch.out_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // offers one byte, optionally after a short gap, and waits for the transfer;
  // valid stays high afterwards so back-to-back bytes need no second write
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.in_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    deframe_byte(b);
  endtask

  // drops valid, waits for every predicted transfer, then lets the back part go quiet
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all three registers, back to back; only called once settled
  task automatic write_cfg(input logic [7:0] h1, input logic [7:0] h2, input logic [6:0] mx);
    cfg_we    <= 1'b1;
    cfg_index <= sfd_pkg::REG_HEADER_FIRST;
    cfg_data  <= h1;
    @(posedge clk);
    cfg_index <= sfd_pkg::REG_HEADER_SECOND;
    cfg_data  <= h2;
    @(posedge clk);
    cfg_index <= sfd_pkg::REG_MAX_FRAME_LEN;
    cfg_data  <= {1'b0, mx};
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr1    = h1;
    hdr2    = h2;
    max_len = mx;
  endtask

  // builds a frame of flen bytes with the current headers; fill < 0 means random payload
  task automatic send_frame(input int flen, input frame_flaw_t flaw, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    int         n_pay;
    sum = hdr1;
    send_byte(hdr1);
    frame_bytes++;
    if (flaw == FLAW_HEAD2) begin
      b = 8'($urandom_range(0, 255));
      if (b == hdr2) b = ~b;
      send_byte(b);
      frame_bytes++;
      return;
    end
    send_byte(hdr2);
    sum = sum + hdr2;
    send_byte(flen[7:0]);
    sum = sum + flen[7:0];
    frame_bytes += 2;
    // out-of-range length: block is back to hunting already
    if (flen < sfd_pkg::MIN_FRAME_LEN || flen > eff_limit()) return;
    n_pay = flen - 4;
    if (flaw == FLAW_TRUNC) n_pay = $urandom_range(0, n_pay - 1);
    for (int i = 0; i < n_pay; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      sum = sum + b;
      send_byte(b);
      frame_bytes++;
    end
    if (flaw == FLAW_TRUNC) return;
    if (flaw == FLAW_CSUM) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    send_byte(sum);
    frame_bytes++;
  endtask

  // mostly short frames, now and then one up to the limit
  function automatic int pick_len();
    int lim;
    lim = eff_limit();
    if (lim < sfd_pkg::MIN_FRAME_LEN) return $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0) return $urandom_range(sfd_pkg::MIN_FRAME_LEN, lim);
    return $urandom_range(sfd_pkg::MIN_FRAME_LEN, (lim < 14) ? lim : 14);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: shortest frame, payload extremes, each error kind
  task automatic test_directed();
    send_frame(5, FLAW_NONE, 0);
    send_frame(6, FLAW_NONE, 255);
    send_frame(5, FLAW_CSUM, -1);
    send_frame(sfd_pkg::MIN_FRAME_LEN - 1, FLAW_NONE, -1);  // length too small
    send_frame(61, FLAW_NONE, -1);                          // one above the reset maximum
    // first header twice: the second one is a bad second header and is not
    // taken as a new first header, so the real second header is then ignored
    send_byte(hdr1);
    send_byte(hdr1);
    send_byte(hdr2);
    send_byte(8'h00);
    settle();
  endtask

  // register extremes, each with frames at and around the limit
  task automatic test_register_settings();
    write_cfg(8'h00, 8'hFF, 7'd64);
    send_frame(64, FLAW_NONE, -1);  // full store
    send_frame(65, FLAW_NONE, -1);
    send_frame(7, FLAW_CSUM, -1);
    send_frame(9, FLAW_HEAD2, -1);
    send_frame(8, FLAW_NONE, -1);
    settle();

    write_cfg(8'hFF, 8'h00, 7'd5);
    send_frame(5, FLAW_NONE, 255);
    send_frame(6, FLAW_NONE, -1);
    send_frame(5, FLAW_NONE, -1);
    settle();

    // maximum below the shortest frame rejects everything; equal headers too
    write_cfg(8'h3C, 8'h3C, 7'd4);
    send_frame(5, FLAW_NONE, -1);
    send_frame(4, FLAW_NONE, -1);
    settle();

    // register above the store size is capped
    write_cfg(8'hAA, 8'h55, 7'd127);
    send_frame(65, FLAW_NONE, -1);
    send_frame(100, FLAW_NONE, -1);
    send_frame(255, FLAW_NONE, -1);
    settle();
  endtask

  // receiver holds off long enough for one bank and the command queue to fill
  // and the byte side to stall, then the sender waits for a full drain
  task automatic test_backpressure();
    write_cfg(sfd_pkg::HEADER_FIRST_RST, sfd_pkg::HEADER_SECOND_RST, sfd_pkg::MAX_LEN_RST);
    hold_left = LONG_HOLD;
    send_frame($urandom_range(10, 18), FLAW_NONE, -1);
    send_frame($urandom_range(10, 18), FLAW_CSUM, -1);
    send_frame($urandom_range(10, 18), FLAW_CSUM, -1);
    send_frame($urandom_range(10, 18), FLAW_NONE, -1);
    send_frame($urandom_range(10, 18), FLAW_NONE, -1);
    settle();
  endtask

  // mostly well-formed frames with random content, some noise and broken frames;
  // three register settings, the last without any idling
  task automatic test_random();
    int sel;
    int len;
    int lim;
    int start;
    start = frame_bytes;
    for (int round = 0; round < 3; round++) begin
      write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                7'($urandom_range(sfd_pkg::MIN_FRAME_LEN, sfd_pkg::MAX_FRAME_BYTES)));
      idle_on = (round < 2);
      while (frame_bytes - start < RANDOM_ITEMS * (round + 1) / 3) begin
        sel = $urandom_range(0, 9);
        lim = eff_limit();
        case (sel)
          0: begin
            // line noise between frames
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          end
          1: send_frame(pick_len(), FLAW_HEAD2, -1);
          2: begin
            len = $urandom_range(0, 1) ? $urandom_range(0, sfd_pkg::MIN_FRAME_LEN - 1)
                                       : $urandom_range(lim + 1, 255);
            send_frame(len, FLAW_NONE, -1);
          end
          3: send_frame(pick_len(), FLAW_CSUM, -1);
          4: send_frame(pick_len(), FLAW_TRUNC, -1);
          default: send_frame(pick_len(), FLAW_NONE, -1);
        endcase
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count  = 0;
    cycles      = 0;
    frame_bytes = 0;
    idle_on     = 1'b1;
    hold_left   = 0;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.in_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_index     <= sfd_pkg::REG_HEADER_FIRST;
    cfg_data      <= 8'h00;
    deframe_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_settings();
    test_backpressure();
    test_random();

    settle();
    if (fail_count == 0) begin
      $display("** serial_frame_deframer_sum8: PASSED **");
    end else begin
      $display("** serial_frame_deframer_sum8: FAILED **");
    end
    $finish;
  end

endmodule
